// ===== sv/etst_pkg.sv =====
`default_nettype none
package etst_pkg;

  // Default sizes of the execution table
  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int APP_SLOTS_DEF     = 4;

  // Reset values
  localparam logic [31:0] PID_START       = 32'd100;
  localparam logic        SHMEM_RESET     = 1'b1;
  localparam logic [5:0]  CHAN_BASE_RESET = 6'd34;

  // Configuration register indexes (byte address 4*index)
  typedef enum logic [0:0] {
    REG_SHMEM     = 1'b0,
    REG_CHAN_BASE = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    CMD_LAUNCH = 3'd0,
    CMD_STATUS = 3'd1,
    CMD_WAIT   = 3'd2,
    CMD_KILL   = 3'd3,
    CMD_BAD    = 3'd4,
    CMD_NOTIFY = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_FAIL    = 3'd1,
    STS_FULL    = 3'd2,
    STS_NO_SLOT = 3'd3,
    STS_BAD_OP  = 3'd4
  } sts_t;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_LOADING = 2'd1,
    ST_RUNNING = 2'd2,
    ST_DONE    = 2'd3
  } ent_state_t;

  // Reply lengths in words
  localparam logic [1:0] WORDS_SHORT  = 2'd1;
  localparam logic [1:0] WORDS_PID    = 2'd2;
  localparam logic [1:0] WORDS_STATUS = 2'd3;

  typedef struct packed {
    logic        shmem_mapped;
    logic [5:0]  slot_channel_base;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] exec_id;
    logic [31:0] cap_bits;
    logic        binary_is_wasm;
    logic [5:0]  channel;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  exec_id_out;
    logic [1:0]  task_state;
    logic [31:0] pid;
    logic [1:0]  slot_out;
    logic [31:0] cap_mask_out;
    logic        binary_type;
    logic [1:0]  reply_words;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/etst_regs.sv =====
`default_nettype none
module etst_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output etst_pkg::cfg_t     cfg
);

  etst_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = etst_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write a register in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shmem_mapped      <= etst_pkg::SHMEM_RESET;
      cfg.slot_channel_base <= etst_pkg::CHAN_BASE_RESET;
    end else if (wr_en) begin
      unique case (idx)
        etst_pkg::REG_SHMEM:     cfg.shmem_mapped      <= pwdata[0];
        etst_pkg::REG_CHAN_BASE: cfg.slot_channel_base <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      etst_pkg::REG_SHMEM:     prdata = {31'd0, cfg.shmem_mapped};
      etst_pkg::REG_CHAN_BASE: prdata = {26'd0, cfg.slot_channel_base};
      default:                 prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/etst_table.sv =====
`default_nettype none
module etst_table #(
  parameter int TABLE_ENTRIES = etst_pkg::TABLE_ENTRIES_DEF,
  parameter int APP_SLOTS     = etst_pkg::APP_SLOTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire etst_pkg::cfg_t cfg,
  input  wire etst_pkg::req_t req,
  input  wire logic           fire,
  output etst_pkg::res_t      res,
  output logic                has_res
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SLOT_W = (APP_SLOTS > 1) ? $clog2(APP_SLOTS) : 1;

  // Entry store; the capability mask is forwarded directly and never read back
  etst_pkg::ent_state_t state [TABLE_ENTRIES];
  logic [SLOT_W-1:0]    slot  [TABLE_ENTRIES];
  logic [31:0]          pid   [TABLE_ENTRIES];
  logic [31:0]          pid_counter;

  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [APP_SLOTS-1:0] used;
  logic                 slot_found;
  logic [SLOT_W-1:0]    slot_idx;
  logic [6:0]           chan_diff;
  logic                 chan_hit;
  logic [SLOT_W-1:0]    chan_slot;
  logic                 ntf_found;
  logic [IDX_W-1:0]     ntf_idx;
  logic                 id_in_range;
  logic [31:0]          id_minus;
  logic [IDX_W-1:0]     lk_idx;
  logic                 lk_found;
  logic                 do_launch;
  logic                 do_kill;
  logic                 do_notify;
  logic [IDX_W:0]       new_id;
  etst_pkg::cmd_t       cmd;

  function automatic logic is_live(etst_pkg::ent_state_t s);
    return (s == etst_pkg::ST_LOADING) || (s == etst_pkg::ST_RUNNING);
  endfunction

  // Find the lowest free entry and the lowest unheld app slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!free_found && state[i] == etst_pkg::ST_FREE) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
    used = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (is_live(state[i])) used[slot[i]] = 1'b1;
    end
    slot_found = 1'b0;
    slot_idx   = '0;
    for (int s = 0; s < APP_SLOTS; s++) begin
      if (!slot_found && !used[s]) begin
        slot_found = 1'b1;
        slot_idx   = SLOT_W'(s);
      end
    end
  end

  // Map a notification channel to a slot and find its first live entry
  always_comb begin
    chan_diff = {1'b0, req.channel} - {1'b0, cfg.slot_channel_base};
    chan_hit  = (req.channel >= cfg.slot_channel_base) && (chan_diff < 7'(APP_SLOTS));
    chan_slot = SLOT_W'(chan_diff);
    ntf_found = 1'b0;
    ntf_idx   = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!ntf_found && slot[i] == chan_slot && is_live(state[i])) begin
        ntf_found = 1'b1;
        ntf_idx   = IDX_W'(i);
      end
    end
  end

  // Look up an exec id
  assign id_in_range = (req.exec_id != 32'd0) && (req.exec_id <= 32'(TABLE_ENTRIES));
  assign id_minus    = req.exec_id - 32'd1;
  assign lk_idx      = id_minus[IDX_W-1:0];
  assign lk_found    = id_in_range && (state[lk_idx] != etst_pkg::ST_FREE);
  assign new_id      = {1'b0, free_idx} + (IDX_W+1)'(1);
  assign cmd         = etst_pkg::cmd_t'(req.command);

  // Build the reply and the table updates
  always_comb begin
    res             = '0;
    res.reply_words = etst_pkg::WORDS_SHORT;
    has_res         = 1'b1;
    do_launch       = 1'b0;
    do_kill         = 1'b0;
    do_notify       = 1'b0;
    unique case (cmd)
      etst_pkg::CMD_LAUNCH: begin
        if (!cfg.shmem_mapped) begin
          res.status = etst_pkg::STS_FAIL;
        end else if (!free_found) begin
          res.status = etst_pkg::STS_FULL;
        end else if (!slot_found) begin
          res.status = etst_pkg::STS_NO_SLOT;
        end else begin
          do_launch        = 1'b1;
          res.status       = etst_pkg::STS_OK;
          res.exec_id_out  = 4'(new_id);
          res.pid          = pid_counter;
          res.slot_out     = 2'(slot_idx);
          res.cap_mask_out = req.cap_bits;
          res.binary_type  = req.binary_is_wasm;
          res.reply_words  = etst_pkg::WORDS_PID;
        end
      end
      etst_pkg::CMD_STATUS: begin
        if (!lk_found) begin
          res.status = etst_pkg::STS_FAIL;
        end else begin
          res.task_state  = state[lk_idx];
          res.pid         = pid[lk_idx];
          res.reply_words = etst_pkg::WORDS_STATUS;
        end
      end
      etst_pkg::CMD_WAIT: begin
        if (!lk_found || state[lk_idx] != etst_pkg::ST_RUNNING) begin
          res.status = etst_pkg::STS_FAIL;
        end else begin
          res.pid         = pid[lk_idx];
          res.reply_words = etst_pkg::WORDS_PID;
        end
      end
      etst_pkg::CMD_KILL: begin
        if (!lk_found) res.status = etst_pkg::STS_FAIL;
        else           do_kill    = 1'b1;
      end
      etst_pkg::CMD_NOTIFY: begin
        has_res   = 1'b0;
        do_notify = chan_hit && ntf_found;
      end
      default: res.status = etst_pkg::STS_BAD_OP;
    endcase
  end

  // Update entry states; entries are freed only by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) state[i] <= etst_pkg::ST_FREE;
      pid_counter <= etst_pkg::PID_START;
    end else if (fire) begin
      if (do_launch) begin
        state[free_idx] <= etst_pkg::ST_RUNNING;
        pid_counter     <= pid_counter + 32'd1;
      end
      if (do_kill)   state[lk_idx]  <= etst_pkg::ST_DONE;
      if (do_notify) state[ntf_idx] <= etst_pkg::ST_DONE;
    end
  end

  // Store slot and pid of a launched entry
  always_ff @(posedge clk) begin
    if (fire && do_launch) begin
      slot[free_idx] <= slot_idx;
      pid[free_idx]  <= pid_counter;
    end
  end

endmodule
`default_nettype wire

// ===== sv/exec_task_slot_table_unit.sv =====
`default_nettype none
// Channel   Direction  Handshake            Contents
// command   in         cmd_valid/cmd_stall  command, exec_id, cap_bits, binary_is_wasm, channel
// result    out        res_valid/res_stall  status, exec_id_out, task_state, pid, slot_out,
//                                           cap_mask_out, binary_type, reply_words
// config    in         APB psel/penable     shmem_mapped at 0, slot_channel_base at 4
//
// One request per cycle while the result side does not stall: a request is registered,
// then the table is searched and updated as the reply is loaded into the result register.
// Slot notifications give no reply and never wait on the result side.
// Synchronous reset frees every entry and sets the pid counter to 100.
// A stalled result holds the result register; the held request waits behind it.
module exec_task_slot_table_unit #(
  parameter int TABLE_ENTRIES = etst_pkg::TABLE_ENTRIES_DEF,
  parameter int APP_SLOTS     = etst_pkg::APP_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] exec_id,
  input  wire logic [31:0] cap_bits,
  input  wire logic        binary_is_wasm,
  input  wire logic [5:0]  channel,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [2:0]       status,
  output logic [3:0]       exec_id_out,
  output logic [1:0]       task_state,
  output logic [31:0]      pid,
  output logic [1:0]       slot_out,
  output logic [31:0]      cap_mask_out,
  output logic             binary_type,
  output logic [1:0]       reply_words,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  etst_pkg::cfg_t cfg;
  etst_pkg::req_t hold;
  etst_pkg::res_t res;
  etst_pkg::res_t res_q;
  logic           hold_valid;
  logic           has_res;
  logic           res_free;
  logic           advance;
  logic           accept;

  etst_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  etst_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .APP_SLOTS     (APP_SLOTS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .req     (hold),
    .fire    (advance),
    .res     (res),
    .has_res (has_res)
  );

  // Move the held request on when its reply has somewhere to go
  assign res_free  = !res_valid || !res_stall;
  assign advance   = hold_valid && (!has_res || res_free);
  assign cmd_stall = hold_valid && !advance;
  assign accept    = cmd_valid && !cmd_stall;

  // Hold the incoming request
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold.command        <= command;
      hold.exec_id        <= exec_id;
      hold.cap_bits       <= cap_bits;
      hold.binary_is_wasm <= binary_is_wasm;
      hold.channel        <= channel;
    end
  end

  // Load the result register; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= advance && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && advance && has_res) res_q <= res;
  end

  assign status       = res_q.status;
  assign exec_id_out  = res_q.exec_id_out;
  assign task_state   = res_q.task_state;
  assign pid          = res_q.pid;
  assign slot_out     = res_q.slot_out;
  assign cap_mask_out = res_q.cap_mask_out;
  assign binary_type  = res_q.binary_type;
  assign reply_words  = res_q.reply_words;

endmodule
`default_nettype wire
